### sv/swalk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_pkg
// Shared types, codes and helpers of the subnet address walker.
// ----------------------------------------------------------------------------
package swalk_pkg;

  localparam int ADDR_W    = 32;
  localparam int PFX_W     = 6;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CUR_W     = 34;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  localparam int ENTRY_W   = 2 * ADDR_W;

  localparam logic [PFX_W-1:0]       PFX_RESET = PFX_W'(32);
  localparam logic signed [CUR_W-1:0] CUR_ONE  = CUR_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_WALKING = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBNET_BASE   = 1'b0,
    REG_SUBNET_PREFIX = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic ins_rd;
    logic ins_place;
    logic ins_shift;
    logic nxt_rd;
    logic nxt_jump;
    logic nxt_adv;
    logic nxt_fin;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic walking;
    logic full;
    logic exhausted;
    logic k_zero;
    logic precedes;
    logic ptr_end;
    logic in_range;
    logic past_end;
    logic skipping;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] host_mask(input logic [PFX_W-1:0] pfx);
    logic [PFX_W-1:0] p;
    p = (pfx > PFX_W'(32)) ? PFX_W'(32) : pfx;
    return {ADDR_W{1'b1}} >> p;
  endfunction

  function automatic logic signed [CUR_W-1:0] to_cur(input logic [ADDR_W-1:0] a);
    return $signed({2'b00, a});
  endfunction

endpackage

### sv/swalk_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_in_if
// Command channel: valid/ready handshake with command and exclusion payload.
// ----------------------------------------------------------------------------
interface swalk_in_if;
  logic                           valid;
  logic                           ready;
  logic [swalk_pkg::CMD_W-1:0]    command;
  logic [swalk_pkg::ADDR_W-1:0]   exclude_addr;
  logic [swalk_pkg::PFX_W-1:0]    exclude_prefix;

  modport source (output valid, command, exclude_addr, exclude_prefix, input ready);
  modport sink   (input valid, command, exclude_addr, exclude_prefix, output ready);
endinterface

### sv/swalk_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_out_if
// Result channel: valid/ready handshake with address, flag and status.
// ----------------------------------------------------------------------------
interface swalk_out_if;
  logic                           valid;
  logic                           ready;
  logic [swalk_pkg::ADDR_W-1:0]   addr;
  logic                           addr_valid;
  logic [swalk_pkg::STAT_W-1:0]   status;

  modport source (output valid, addr, addr_valid, status, input ready);
  modport sink   (input valid, addr, addr_valid, status, output ready);
endinterface

### sv/swalk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swalk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/swalk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_ctrl
// Sequencer for begin, sorted insert and next-address search.
// ----------------------------------------------------------------------------
module swalk_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [swalk_pkg::CMD_W-1:0] in_command,
  output logic                        in_ready,
  input  swalk_pkg::dp_stat_t         stat,
  output swalk_pkg::dp_cmd_t          cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_CMP = 7'b0000100,
    S_NXT_RD  = 7'b0001000,
    S_NXT_CMP = 7'b0010000,
    S_NXT_FIN = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          unique case (swalk_pkg::cmd_t'(in_command))
            swalk_pkg::CMD_INSERT: begin
              state_nxt = (stat.walking || stat.full) ? S_DONE : S_INS_RD;
            end
            swalk_pkg::CMD_NEXT: begin
              state_nxt = stat.exhausted ? S_DONE : S_NXT_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        if (stat.k_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.precedes) begin
          cmd.ins_place = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end
      end
      S_NXT_RD: begin
        if (stat.ptr_end) begin
          state_nxt = S_NXT_FIN;
        end else begin
          cmd.nxt_rd = 1'b1;
          state_nxt  = S_NXT_CMP;
        end
      end
      S_NXT_CMP: begin
        if (stat.in_range) begin
          cmd.nxt_jump = 1'b1;
          state_nxt    = S_NXT_RD;
        end else if (stat.skipping && stat.past_end) begin
          cmd.nxt_adv = 1'b1;
          state_nxt   = S_NXT_RD;
        end else begin
          state_nxt = S_NXT_FIN;
        end
      end
      S_NXT_FIN: begin
        cmd.nxt_fin = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/swalk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swalk_dp
// Datapath: configuration, cursor, exclusion table, result and output stage.
// ----------------------------------------------------------------------------
module swalk_dp #(
  parameter int MAX_EXCLUSIONS = 16,
  parameter int AW             = 4,
  parameter int CW             = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swalk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swalk_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic [swalk_pkg::CMD_W-1:0]     in_command,
  input  logic [swalk_pkg::ADDR_W-1:0]    in_exclude_addr,
  input  logic [swalk_pkg::PFX_W-1:0]     in_exclude_prefix,
  input  swalk_pkg::dp_cmd_t              cmd,
  output swalk_pkg::dp_stat_t             stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [swalk_pkg::ADDR_W-1:0]    out_addr,
  output logic                            out_addr_valid,
  output logic [swalk_pkg::STAT_W-1:0]    out_status
);

  logic [swalk_pkg::ADDR_W-1:0]       base_r;
  logic [swalk_pkg::PFX_W-1:0]        prefix_r;
  logic signed [swalk_pkg::CUR_W-1:0] cursor_r;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      ptr_r;
  logic [AW-1:0]                      k_r;
  logic                               walking_r;
  logic                               skip_r;
  logic [swalk_pkg::ADDR_W-1:0]       new_s_r;
  logic [swalk_pkg::ADDR_W-1:0]       new_e_r;
  logic [swalk_pkg::ADDR_W-1:0]       res_addr_r;
  logic                               res_valid_r;
  swalk_pkg::status_t                 res_status_r;
  logic                               out_valid_r;
  logic [swalk_pkg::ADDR_W-1:0]       out_addr_r;
  logic                               out_addr_valid_r;
  logic [swalk_pkg::STAT_W-1:0]       out_status_r;

  logic [swalk_pkg::ADDR_W-1:0]       net_mask;
  logic [swalk_pkg::ADDR_W-1:0]       net_start;
  logic signed [swalk_pkg::CUR_W-1:0] net_final;
  logic [swalk_pkg::ADDR_W-1:0]       exc_mask;
  logic [swalk_pkg::ADDR_W-1:0]       exc_s;
  logic [swalk_pkg::ADDR_W-1:0]       exc_e;
  logic [swalk_pkg::ENTRY_W-1:0]      rd_data;
  logic [swalk_pkg::ENTRY_W-1:0]      wr_data;
  logic [swalk_pkg::ADDR_W-1:0]       ent_s;
  logic [swalk_pkg::ADDR_W-1:0]       ent_e;
  logic [AW-1:0]                      rd_addr;
  logic                               wr_en;

  assign net_mask  = swalk_pkg::host_mask(prefix_r);
  assign net_start = base_r & ~net_mask;
  assign net_final = swalk_pkg::to_cur(net_start | net_mask);

  assign exc_mask  = swalk_pkg::host_mask(in_exclude_prefix);
  assign exc_s     = in_exclude_addr & ~exc_mask;
  assign exc_e     = exc_s | exc_mask;

  assign ent_s     = rd_data[swalk_pkg::ENTRY_W-1:swalk_pkg::ADDR_W];
  assign ent_e     = rd_data[swalk_pkg::ADDR_W-1:0];

  assign wr_en     = cmd.ins_place || cmd.ins_shift;
  assign wr_data   = cmd.ins_place ? {new_s_r, new_e_r} : rd_data;
  assign rd_addr   = cmd.ins_rd ? (k_r - AW'(1)) : ptr_r[AW-1:0];

  swalk_ram #(
    .WIDTH (swalk_pkg::ENTRY_W),
    .DEPTH (MAX_EXCLUSIONS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (k_r),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    stat.walking   = walking_r;
    stat.full      = (count_r == CW'(MAX_EXCLUSIONS));
    stat.exhausted = (cursor_r >= net_final);
    stat.k_zero    = (k_r == '0);
    stat.precedes  = (ent_s < new_s_r) || ((ent_s == new_s_r) && (ent_e >= new_e_r));
    stat.ptr_end   = (ptr_r >= count_r);
    stat.in_range  = (cursor_r >= swalk_pkg::to_cur(ent_s)) &&
                     (cursor_r <= swalk_pkg::to_cur(ent_e));
    stat.past_end  = (cursor_r > swalk_pkg::to_cur(ent_e));
    stat.skipping  = skip_r;
    stat.out_busy  = out_valid_r && !out_ready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      prefix_r <= swalk_pkg::PFX_RESET;
    end else if (cfg_we) begin
      unique case (swalk_pkg::reg_idx_t'(cfg_index))
        swalk_pkg::REG_SUBNET_BASE:   base_r   <= cfg_data;
        swalk_pkg::REG_SUBNET_PREFIX: prefix_r <= cfg_data[swalk_pkg::PFX_W-1:0];
        default: ;
      endcase
    end
  end

  // walk and table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= -swalk_pkg::CUR_ONE;
      count_r   <= '0;
      ptr_r     <= '0;
      walking_r <= 1'b0;
      skip_r    <= 1'b0;
      k_r       <= '0;
    end else begin
      if (cmd.accept) begin
        unique case (swalk_pkg::cmd_t'(in_command))
          swalk_pkg::CMD_BEGIN: begin
            cursor_r  <= swalk_pkg::to_cur(net_start) - swalk_pkg::CUR_ONE;
            count_r   <= '0;
            ptr_r     <= '0;
            walking_r <= 1'b0;
          end
          swalk_pkg::CMD_INSERT: begin
            k_r <= count_r[AW-1:0];
          end
          swalk_pkg::CMD_NEXT: begin
            walking_r <= 1'b1;
            skip_r    <= 1'b0;
            if (cursor_r < net_final) begin
              cursor_r <= cursor_r + swalk_pkg::CUR_ONE;
            end
          end
          default: ;
        endcase
      end
      if (cmd.ins_place) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.ins_shift) begin
        k_r <= k_r - AW'(1);
      end
      if (cmd.nxt_jump) begin
        cursor_r <= swalk_pkg::to_cur(ent_e) + swalk_pkg::CUR_ONE;
        ptr_r    <= ptr_r + CW'(1);
        skip_r   <= 1'b1;
      end
      if (cmd.nxt_adv) begin
        ptr_r <= ptr_r + CW'(1);
      end
    end
  end

  // pending range and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_s_r      <= exc_s;
      new_e_r      <= exc_e;
      res_addr_r   <= '0;
      res_valid_r  <= 1'b0;
      res_status_r <= swalk_pkg::ST_OK;
      if (swalk_pkg::cmd_t'(in_command) == swalk_pkg::CMD_INSERT) begin
        if (walking_r) begin
          res_status_r <= swalk_pkg::ST_WALKING;
        end else if (count_r == CW'(MAX_EXCLUSIONS)) begin
          res_status_r <= swalk_pkg::ST_FULL;
        end
      end
    end
    if (cmd.nxt_fin && (cursor_r <= net_final)) begin
      res_addr_r  <= cursor_r[swalk_pkg::ADDR_W-1:0];
      res_valid_r <= 1'b1;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr_r       <= res_addr_r;
      out_addr_valid_r <= res_valid_r;
      out_status_r     <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_addr       = out_addr_r;
  assign out_addr_valid = out_addr_valid_r;
  assign out_status     = out_status_r;

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= count_r)
    else $error("range pointer beyond table fill");

  a_rd_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.nxt_rd |-> ptr_r < count_r)
    else $error("range read past table fill");

  a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
    walking_r && !(cmd.accept && (in_command == swalk_pkg::CMD_BEGIN)) |=> walking_r)
    else $error("walking flag dropped without begin");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a pending beat");

  a_load_show: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_addr_valid_r |-> out_addr_r == '0)
    else $error("address nonzero on an invalid result");

endmodule

### sv/subnet_address_walker_with_exclusions.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subnet_address_walker_with_exclusions
// Walks a configured IPv4 subnet in ascending order, skipping excluded subnets.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and each yields exactly one result beat.
// A begin, an unknown command, a refused insert and an exhausted next go
// straight to the result load. An accepted insert moves each table entry
// that sorts after the new range up one slot, starting at the tail, then
// places the new range: the sorted table lives in a single-port-read RAM and
// is shifted one entry per read/write pair. A next reads the table entries
// it meets while skipping excluded ranges, one RAM read per entry.
// A finished result sits in an output register so a new command can be taken
// while it waits; the next result is held back until that beat is taken.
// ----------------------------------------------------------------------------
module subnet_address_walker_with_exclusions #(
  parameter int MAX_EXCLUSIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [swalk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swalk_pkg::CFG_DAT_W-1:0] cfg_data,
  swalk_in_if.sink                        in_ch,
  swalk_out_if.source                     out_ch
);

  localparam int AW = (MAX_EXCLUSIONS > 1) ? $clog2(MAX_EXCLUSIONS) : 1;
  localparam int CW = $clog2(MAX_EXCLUSIONS + 1);

  swalk_pkg::dp_cmd_t  dp_cmd;
  swalk_pkg::dp_stat_t dp_stat;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  swalk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  swalk_dp #(
    .MAX_EXCLUSIONS (MAX_EXCLUSIONS),
    .AW             (AW),
    .CW             (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_ch.command),
    .in_exclude_addr   (in_ch.exclude_addr),
    .in_exclude_prefix (in_ch.exclude_prefix),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_addr          (out_ch.addr),
    .out_addr_valid    (out_ch.addr_valid),
    .out_status        (out_ch.status)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subnet address walker with exclusions.
// A queue of planned commands and register writes feeds a clocked driver; a
// built-in walker predictor computes each reply as its command beat is taken,
// and a clocked monitor compares every result beat against the oldest pending
// reply. Directed corner cases come first, then randomized subnet phases with
// exclusion tables, full walks, noise commands, random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_EXCL       = 16;
  localparam int ITEM_TARGET    = 1400;
  localparam int HOLD_AFTER     = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [swalk_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    STEP_BEAT,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t                       kind;
    logic [swalk_pkg::CMD_W-1:0]      command;
    logic [swalk_pkg::ADDR_W-1:0]     xaddr;
    logic [swalk_pkg::PFX_W-1:0]      xpfx;
    swalk_pkg::reg_idx_t              reg_idx;
    logic [swalk_pkg::CFG_DAT_W-1:0]  reg_data;
  } step_t;

  typedef struct {
    logic [swalk_pkg::ADDR_W-1:0] addr;
    logic                         addr_valid;
    swalk_pkg::status_t           status;
  } reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             cfg_we    = 1'b0;
  swalk_pkg::reg_idx_t              cfg_index = swalk_pkg::REG_SUBNET_BASE;
  logic [swalk_pkg::CFG_DAT_W-1:0]  cfg_data  = '0;

  logic                             drv_valid = 1'b0;
  logic [swalk_pkg::CMD_W-1:0]      drv_cmd   = '0;
  logic [swalk_pkg::ADDR_W-1:0]     drv_addr  = '0;
  logic [swalk_pkg::PFX_W-1:0]      drv_pfx   = '0;
  logic                             rx_ready  = 1'b0;

  swalk_in_if  in_ch ();
  swalk_out_if out_ch ();

  assign in_ch.valid          = drv_valid;
  assign in_ch.command        = drv_cmd;
  assign in_ch.exclude_addr   = drv_addr;
  assign in_ch.exclude_prefix = drv_pfx;
  assign out_ch.ready         = rx_ready;

  subnet_address_walker_with_exclusions i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #6 clk = ~clk;

  // walker predictor state
  logic [swalk_pkg::ADDR_W-1:0]        cfg_base;
  logic [swalk_pkg::PFX_W-1:0]         cfg_pfx;
  logic signed [swalk_pkg::CUR_W-1:0]  walk_pos;
  logic [swalk_pkg::ADDR_W-1:0]        excl_lo [MAX_EXCL];
  logic [swalk_pkg::ADDR_W-1:0]        excl_hi [MAX_EXCL];
  logic [4:0]                          excl_count;
  logic [4:0]                          excl_next;
  logic                                walk_started;

  step_t   cmd_plan [$];
  reply_t  pending_replies [$];
  step_t   cur_beat;

  int n_issued = 0;
  int n_returned = 0;
  int errors = 0;
  int idle_cycles = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int rx_hold = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit rx_hold_done = 1'b0;
  bit tx_offer;
  bit tx_we;
  int real_items = 0;

  int n_begin = 0, n_insert = 0, n_next = 0, n_unknown = 0, n_cfg = 0;
  int n_addr = 0, n_dry = 0, n_full = 0, n_late = 0;

  function automatic logic [swalk_pkg::ADDR_W-1:0] span_mask(
      input logic [swalk_pkg::PFX_W-1:0] pfx);
    logic [swalk_pkg::ADDR_W:0] ones;
    if (pfx >= 6'd32) return '0;
    ones = (33'd1 << (6'd32 - pfx)) - 33'd1;
    return ones[swalk_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic signed [swalk_pkg::CUR_W-1:0] wide(
      input logic [swalk_pkg::ADDR_W-1:0] a);
    logic signed [swalk_pkg::CUR_W-1:0] w;
    w = $signed({2'b00, a});
    return w;
  endfunction

  function automatic void restart_walk();
    excl_count   = '0;
    excl_next    = '0;
    walk_started = 1'b0;
    walk_pos     = wide(cfg_base & ~span_mask(cfg_pfx)) - swalk_pkg::CUR_ONE;
  endfunction

  function automatic swalk_pkg::status_t add_exclusion(
      input logic [swalk_pkg::ADDR_W-1:0] a, input logic [swalk_pkg::PFX_W-1:0] p);
    logic [swalk_pkg::ADDR_W-1:0] m, lo, hi;
    int pos;
    if (walk_started) return swalk_pkg::ST_WALKING;
    if (excl_count >= MAX_EXCL) return swalk_pkg::ST_FULL;
    m  = span_mask(p);
    lo = a & ~m;
    hi = lo | m;
    pos = 0;
    while (pos < int'(excl_count) &&
           (excl_lo[4'(pos)] < lo ||
            (excl_lo[4'(pos)] == lo && excl_hi[4'(pos)] >= hi)))
      pos++;
    for (int k = int'(excl_count); k > pos; k--) begin
      excl_lo[4'(k)] = excl_lo[4'(k-1)];
      excl_hi[4'(k)] = excl_hi[4'(k-1)];
    end
    excl_lo[4'(pos)] = lo;
    excl_hi[4'(pos)] = hi;
    excl_count++;
    return swalk_pkg::ST_OK;
  endfunction

  function automatic logic step_walk(output logic [swalk_pkg::ADDR_W-1:0] a);
    logic signed [swalk_pkg::CUR_W-1:0] lim;
    lim = wide((cfg_base & ~span_mask(cfg_pfx)) | span_mask(cfg_pfx));
    walk_started = 1'b1;
    a = '0;
    if (walk_pos >= lim) return 1'b0;
    walk_pos = walk_pos + swalk_pkg::CUR_ONE;
    while (excl_next < excl_count &&
           walk_pos >= wide(excl_lo[excl_next[3:0]]) &&
           walk_pos <= wide(excl_hi[excl_next[3:0]])) begin
      walk_pos = wide(excl_hi[excl_next[3:0]]) + swalk_pkg::CUR_ONE;
      do
        excl_next++;
      while (excl_next < excl_count && walk_pos > wide(excl_hi[excl_next[3:0]]));
    end
    if (walk_pos > lim) return 1'b0;
    a = walk_pos[swalk_pkg::ADDR_W-1:0];
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(input step_t b);
    reply_t r;
    r.addr       = '0;
    r.addr_valid = 1'b0;
    r.status     = swalk_pkg::ST_OK;
    case (b.command)
      swalk_pkg::CMD_BEGIN: begin
        n_begin++;
        restart_walk();
      end
      swalk_pkg::CMD_INSERT: begin
        n_insert++;
        r.status = add_exclusion(b.xaddr, b.xpfx);
        if (r.status == swalk_pkg::ST_FULL) n_full++;
        if (r.status == swalk_pkg::ST_WALKING) n_late++;
      end
      swalk_pkg::CMD_NEXT: begin
        n_next++;
        r.addr_valid = step_walk(r.addr);
        if (r.addr_valid) n_addr++;
        else n_dry++;
      end
      default: n_unknown++;
    endcase
    return r;
  endfunction

  function automatic void add_beat(input logic [swalk_pkg::CMD_W-1:0] c,
                                   input logic [swalk_pkg::ADDR_W-1:0] a,
                                   input logic [swalk_pkg::PFX_W-1:0] p);
    step_t s;
    s.kind     = STEP_BEAT;
    s.command  = c;
    s.xaddr    = a;
    s.xpfx     = p;
    s.reg_idx  = swalk_pkg::REG_SUBNET_BASE;
    s.reg_data = '0;
    cmd_plan.push_back(s);
    if (c != CMD_UNKNOWN) real_items++;
  endfunction

  function automatic void add_cfg(input swalk_pkg::reg_idx_t idx,
                                  input logic [swalk_pkg::CFG_DAT_W-1:0] d);
    step_t s;
    s.kind     = STEP_CFG;
    s.command  = swalk_pkg::CMD_BEGIN;
    s.xaddr    = '0;
    s.xpfx     = '0;
    s.reg_idx  = idx;
    s.reg_data = d;
    cmd_plan.push_back(s);
  endfunction

  function automatic void add_drain();
    step_t s;
    s.kind     = STEP_DRAIN;
    s.command  = swalk_pkg::CMD_BEGIN;
    s.xaddr    = '0;
    s.xpfx     = '0;
    s.reg_idx  = swalk_pkg::REG_SUBNET_BASE;
    s.reg_data = '0;
    cmd_plan.push_back(s);
  endfunction

  function automatic int draw_gap(inout bit calm);
    int g;
    g = calm ? 0 : int'($urandom_range(0, 13));
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return g;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      cfg_we    <= 1'b0;
    end else begin
      tx_offer = drv_valid && !in_ch.ready;
      tx_we    = 1'b0;
      if (drv_valid && in_ch.ready) begin
        pending_replies.push_back(predict_reply(cur_beat));
        n_issued++;
        tx_wait = draw_gap(tx_calm);
      end
      if (!tx_offer) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (cmd_plan.size() > 0) begin
          case (cmd_plan[0].kind)
            STEP_BEAT: begin
              cur_beat = cmd_plan.pop_front();
              tx_offer = 1'b1;
              drv_cmd  <= cur_beat.command;
              drv_addr <= cur_beat.xaddr;
              drv_pfx  <= cur_beat.xpfx;
            end
            STEP_CFG: if (n_issued == n_returned) begin
              cur_beat  = cmd_plan.pop_front();
              tx_we     = 1'b1;
              cfg_index <= cur_beat.reg_idx;
              cfg_data  <= cur_beat.reg_data;
              n_cfg++;
              if (cur_beat.reg_idx == swalk_pkg::REG_SUBNET_BASE) cfg_base = cur_beat.reg_data;
              else cfg_pfx = cur_beat.reg_data[swalk_pkg::PFX_W-1:0];
            end
            default: if (n_issued == n_returned) void'(cmd_plan.pop_front());
          endcase
        end
      end
      drv_valid <= tx_offer;
      cfg_we    <= tx_we;
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rx_ready) begin
        if (pending_replies.size() == 0) begin
          $error("result beat with nothing pending: addr %h", out_ch.addr);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.addr !== want.addr) begin
            $error("addr: expected %h, got %h", want.addr, out_ch.addr);
            errors++;
          end
          if (out_ch.addr_valid !== want.addr_valid) begin
            $error("addr_valid: expected %b, got %b", want.addr_valid, out_ch.addr_valid);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
        end
        n_returned <= n_returned + 1;
        rx_wait = draw_gap(rx_calm);
      end
      if (!rx_hold_done && n_returned >= HOLD_AFTER && in_ch.valid) begin
        rx_hold      = HOLD_CYCLES;
        rx_hold_done = 1'b1;
      end
      rx_ready <= (rx_hold == 0) && (rx_wait == 0);
      if (rx_hold > 0) rx_hold--;
      else if (rx_wait > 0) rx_wait--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [swalk_pkg::ADDR_W-1:0] base, hmask, xa;
    logic [swalk_pkg::PFX_W-1:0]  pfx, pe, xp;
    int r, n_ins, n_nxt, phase;

    cfg_base = '0;
    cfg_pfx  = swalk_pkg::PFX_RESET;
    restart_walk();
    xa = '0;
    xp = '0;

    // reset state, single-address subnet at the top of the space
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    add_cfg(swalk_pkg::REG_SUBNET_BASE, 32'hFFFF_FFFF);
    add_cfg(swalk_pkg::REG_SUBNET_PREFIX, 32'd63);
    add_beat(swalk_pkg::CMD_BEGIN, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
    // sorted table with tied starts, duplicates and edge exclusions
    add_cfg(swalk_pkg::REG_SUBNET_BASE, 32'h0A00_0009);
    add_cfg(swalk_pkg::REG_SUBNET_PREFIX, 32'd28);
    add_beat(swalk_pkg::CMD_BEGIN, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0A00_0004, 6'd30);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0A00_0005, 6'd30);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0A00_0004, 6'd63);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0A00_0000, 6'd32);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0A00_000F, 6'd32);
    add_beat(CMD_UNKNOWN, 32'hFFFF_FFFF, 6'd63);
    repeat (4) add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_INSERT, 32'h0, 6'd0);
    // shrink the subnet under the cursor
    add_cfg(swalk_pkg::REG_SUBNET_PREFIX, 32'd30);
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    // whole space excluded
    add_cfg(swalk_pkg::REG_SUBNET_BASE, 32'h0);
    add_cfg(swalk_pkg::REG_SUBNET_PREFIX, 32'd0);
    add_beat(swalk_pkg::CMD_BEGIN, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd0);
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);
    add_beat(swalk_pkg::CMD_NEXT, 32'h0, 6'd0);

    phase = 0;
    while (real_items < ITEM_TARGET) begin
      base = $urandom();
      r = int'($urandom_range(0, 19));
      if (r < 12) pfx = 6'($urandom_range(26, 32));
      else if (r < 15) pfx = 6'($urandom_range(0, 25));
      else if (r < 17) pfx = 6'($urandom_range(33, 63));
      else if (r == 17) pfx = 6'd0;
      else pfx = 6'd32;
      hmask = span_mask(pfx);
      pe = (pfx > 6'd32) ? 6'd32 : pfx;
      if (phase % 5 == 3 || $urandom_range(0, 5) == 0) add_drain();
      add_cfg(swalk_pkg::REG_SUBNET_BASE, base);
      if ($urandom_range(0, 3) == 0) begin
        add_cfg(swalk_pkg::REG_SUBNET_PREFIX, ($urandom() & ~32'h3F) | 32'(pfx));
      end else begin
        add_cfg(swalk_pkg::REG_SUBNET_PREFIX, 32'(pfx));
      end
      if (phase == 0 || $urandom_range(0, 7) != 0) begin
        add_beat(swalk_pkg::CMD_BEGIN, $urandom(), 6'($urandom_range(0, 63)));
        n_ins = (phase % 4 == 1) ? int'($urandom_range(16, 20)) : int'($urandom_range(0, 6));
        for (int k = 0; k < n_ins; k++) begin
          if (k > 0 && $urandom_range(0, 7) == 0) begin
          end else if ($urandom_range(0, 5) == 0) begin
            xa = $urandom();
            xp = 6'($urandom_range(0, 63));
          end else begin
            xa = (base & ~hmask) | ($urandom() & hmask);
            xp = 6'($urandom_range(pe, 32));
          end
          add_beat(swalk_pkg::CMD_INSERT, xa, xp);
        end
      end
      n_nxt = (hmask < 64) ? int'(hmask) + int'($urandom_range(2, 4))
                           : int'($urandom_range(10, 60));
      for (int k = 0; k < n_nxt; k++) begin
        r = int'($urandom_range(0, 39));
        if (r == 0) add_beat(CMD_UNKNOWN, $urandom(), 6'($urandom_range(0, 63)));
        else if (r == 1) add_beat(swalk_pkg::CMD_INSERT, $urandom(), 6'($urandom_range(0, 63)));
        else if (r == 2) add_beat(swalk_pkg::CMD_BEGIN, $urandom(), 6'($urandom_range(0, 63)));
        else add_beat(swalk_pkg::CMD_NEXT, $urandom(), 6'($urandom_range(0, 63)));
      end
      phase++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (cmd_plan.size() != 0 || drv_valid || n_issued != n_returned);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      errors++;
    end
    $display("covered %0d commands: %0d begin, %0d insert, %0d next, %0d unknown; %0d reg writes",
             n_issued, n_begin, n_insert, n_next, n_unknown, n_cfg);
    $display("%0d addresses walked, %0d dry nexts, %0d inserts refused full, %0d after walk start",
             n_addr, n_dry, n_full, n_late);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### subnet_address_walker_with_exclusions.f
sv/swalk_pkg.sv
sv/swalk_in_if.sv
sv/swalk_out_if.sv
sv/swalk_ram.sv
sv/swalk_ctrl.sv
sv/swalk_dp.sv
sv/subnet_address_walker_with_exclusions.sv
test/tb_top.sv
